### rtl/isa_pkg.sv
package isa_pkg;

    localparam int MAX_SLOTS = 256;
    localparam int SLOT_W    = $clog2(MAX_SLOTS);
    localparam int CNT_W     = SLOT_W + 1;
    localparam int CMD_W     = 2;
    localparam int IDX_W     = 8;
    localparam int STATUS_W  = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_QUERY = 2'd2
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_ALLOC = 2'd2
    } status_t;

endpackage

### rtl/index_slot_allocator_core.sv
// Channel   Direction  Handshake              Payload
// command   in         cmd_valid / cmd_stall  cmd, slot_index
// response  out        rsp_valid / rsp_stall  granted_index, status
//
// One command a cycle while cmd_stall is low; each command is registered in
// cmd_reg and answered from the result register. The freed-slot ring is a
// 256-entry memory; its head entry is pre-read into a register, so pops never wait.
// Reset clears pool bounds, ring pointers and the in-use bitmap at once.
// A stalled response holds the result register and then the command register.
module index_slot_allocator_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    output logic                          cmd_stall,
    input  logic [isa_pkg::CMD_W-1:0]     cmd,
    input  logic [isa_pkg::IDX_W-1:0]     slot_index,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output logic [isa_pkg::IDX_W-1:0]     granted_index,
    output logic [isa_pkg::STATUS_W-1:0]  status
);
    import isa_pkg::*;

    logic                 s1_valid_reg;
    logic [CMD_W-1:0]     cmd_reg;
    logic [IDX_W-1:0]     idx_reg;

    logic                 rsp_valid_reg;
    logic [IDX_W-1:0]     granted_reg;
    status_t              status_reg;

    logic [CNT_W-1:0]     pool_capacity_reg, pool_capacity_next;
    logic [CNT_W-1:0]     fresh_next_reg, fresh_next_next;
    logic [CNT_W-1:0]     fresh_low_reg, fresh_low_next;
    logic [SLOT_W-1:0]    ring_head_reg, ring_head_next;
    logic [SLOT_W-1:0]    ring_tail_reg, ring_tail_next;
    logic [CNT_W-1:0]     ring_count_reg, ring_count_next;
    logic [MAX_SLOTS-1:0] slot_in_use_reg, slot_in_use_next;

    logic [SLOT_W-1:0]    freed_ring [MAX_SLOTS];
    logic [SLOT_W-1:0]    head_entry_reg;

    logic                 advance;
    logic                 ring_we;
    logic [IDX_W-1:0]     granted_next;
    status_t              status_next;

    logic                 fresh_empty;
    logic                 ring_empty;
    logic                 grow;
    logic [CNT_W:0]       cap_x2;
    logic [CNT_W-1:0]     grown;
    logic [CNT_W-1:0]     fresh_top;
    logic [SLOT_W-1:0]    take_slot;
    logic                 idx_allocated;

    assign advance   = s1_valid_reg && (!rsp_valid_reg || !rsp_stall);
    assign cmd_stall = s1_valid_reg && !advance;

    assign rsp_valid     = rsp_valid_reg;
    assign granted_index = granted_reg;
    assign status        = status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!cmd_stall)
        begin
            s1_valid_reg <= cmd_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid && !cmd_stall)
        begin
            cmd_reg <= cmd;
            idx_reg <= slot_index;
        end
    end

    assign fresh_empty = fresh_next_reg <= fresh_low_reg;
    assign ring_empty  = ring_count_reg == '0;
    assign grow        = fresh_empty && ring_empty;
    assign cap_x2      = {pool_capacity_reg, 1'b0};

    always_comb
    begin
        if (pool_capacity_reg == '0)
        begin
            grown = CNT_W'(1);
        end
        else if (cap_x2 > (CNT_W+1)'(MAX_SLOTS))
        begin
            grown = CNT_W'(MAX_SLOTS);
        end
        else
        begin
            grown = cap_x2[CNT_W-1:0];
        end
    end

    assign fresh_top     = grow ? grown : fresh_next_reg;
    assign idx_allocated = ({1'b0, idx_reg} < pool_capacity_reg)
                           && slot_in_use_reg[idx_reg[SLOT_W-1:0]];

    always_comb
    begin
        pool_capacity_next = pool_capacity_reg;
        fresh_next_next    = fresh_next_reg;
        fresh_low_next     = fresh_low_reg;
        ring_head_next     = ring_head_reg;
        ring_tail_next     = ring_tail_reg;
        ring_count_next    = ring_count_reg;
        slot_in_use_next   = slot_in_use_reg;
        ring_we            = 1'b0;
        take_slot          = '0;
        granted_next       = idx_reg;
        status_next        = ST_OK;

        case (cmd_reg)
            CMD_ALLOC:
            begin
                if (grow && pool_capacity_reg >= CNT_W'(MAX_SLOTS))
                begin
                    granted_next = '0;
                    status_next  = ST_FULL;
                end
                else
                begin
                    if (grow)
                    begin
                        fresh_low_next     = pool_capacity_reg;
                        pool_capacity_next = grown;
                    end
                    if (grow || !fresh_empty)
                    begin
                        fresh_next_next = fresh_top - CNT_W'(1);
                        take_slot       = fresh_next_next[SLOT_W-1:0];
                    end
                    else
                    begin
                        take_slot       = head_entry_reg;
                        ring_head_next  = ring_head_reg + SLOT_W'(1);
                        ring_count_next = ring_count_reg - CNT_W'(1);
                    end
                    slot_in_use_next[take_slot] = 1'b1;
                    granted_next = IDX_W'(take_slot);
                end
            end
            CMD_FREE:
            begin
                if (idx_allocated && ring_count_reg < CNT_W'(MAX_SLOTS))
                begin
                    slot_in_use_next[idx_reg[SLOT_W-1:0]] = 1'b0;
                    ring_we         = 1'b1;
                    ring_tail_next  = ring_tail_reg + SLOT_W'(1);
                    ring_count_next = ring_count_reg + CNT_W'(1);
                end
                else
                begin
                    status_next = ST_NOT_ALLOC;
                end
            end
            default:
            begin
                status_next = idx_allocated ? ST_OK : ST_NOT_ALLOC;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_capacity_reg <= '0;
            fresh_next_reg    <= '0;
            fresh_low_reg     <= '0;
            ring_head_reg     <= '0;
            ring_tail_reg     <= '0;
            ring_count_reg    <= '0;
            slot_in_use_reg   <= '0;
            rsp_valid_reg     <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                pool_capacity_reg <= pool_capacity_next;
                fresh_next_reg    <= fresh_next_next;
                fresh_low_reg     <= fresh_low_next;
                ring_head_reg     <= ring_head_next;
                ring_tail_reg     <= ring_tail_next;
                ring_count_reg    <= ring_count_next;
                slot_in_use_reg   <= slot_in_use_next;
                rsp_valid_reg     <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            granted_reg <= granted_next;
            status_reg  <= status_next;
        end
    end

    // keep head_entry_reg equal to the entry at the head, bypassing a same-cycle write
    always_ff @(posedge clk)
    begin
        if (advance && ring_we)
        begin
            freed_ring[ring_tail_reg] <= idx_reg[SLOT_W-1:0];
        end
        if (advance && ring_we && ring_tail_reg == ring_head_next)
        begin
            head_entry_reg <= idx_reg[SLOT_W-1:0];
        end
        else
        begin
            head_entry_reg <= freed_ring[advance ? ring_head_next : ring_head_reg];
        end
    end

    a_ring_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ring_count_reg <= CNT_W'(MAX_SLOTS))
        else $error("freed ring count beyond pool size");

    a_fresh_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fresh_low_reg <= fresh_next_reg && fresh_next_reg <= pool_capacity_reg)
        else $error("fresh range outside pool");

    a_cap_shape: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(pool_capacity_reg))
        else $error("pool capacity not a power of two");

    a_full_at_max: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && status_reg == ST_FULL |-> pool_capacity_reg == CNT_W'(MAX_SLOTS))
        else $error("full reported below maximum capacity");

    a_slot_balance: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(slot_in_use_reg) + int'(fresh_next_reg - fresh_low_reg)
        + int'(ring_count_reg) == int'(pool_capacity_reg))
        else $error("slot accounting out of balance");

endmodule
